>>> src/b2b_pkg.sv
// ----------------------------------------------------------------------------
// b2b_pkg: shared definitions for the BLAKE2b word hash engine
// Request codes, sequencer states, the initialization vector and the
// message schedule used by the compression sequencer.
// ----------------------------------------------------------------------------
package b2b_pkg;

	typedef enum logic [1:0] {
		ACT_BEGIN  = 2'd0,
		ACT_KEY    = 2'd1,
		ACT_DATA   = 2'd2,
		ACT_FINISH = 2'd3
	} act_t;

	typedef enum logic [1:0] {
		CFG_DIGEST_WORDS = 2'd0,
		CFG_KEY_WORDS    = 2'd1
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INIT,
		ST_MIX,
		ST_FINAL,
		ST_EMIT
	} st_t;

	localparam logic [63:0] PARAM_BASE = 64'h0000_0000_0101_0000;
	localparam logic [7:0]  BLOCK_BYTES = 8'd128;
	localparam logic [3:0]  LAST_ROUND = 4'd11;
	localparam logic [3:0]  LAST_SIGMA = 4'd9;

	localparam logic [63:0] IV [8] = '{
		64'h6A09E667F3BCC908, 64'hBB67AE8584CAA73B,
		64'h3C6EF372FE94F82B, 64'hA54FF53A5F1D36F1,
		64'h510E527FADE682D1, 64'h9B05688C2B3E6C1F,
		64'h1F83D9ABFB41BD6B, 64'h5BE0CD19137E2179
	};

	localparam logic [3:0] SIGMA [10][16] = '{
		'{4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7,
		  4'd8, 4'd9, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15},
		'{4'd14, 4'd10, 4'd4, 4'd8, 4'd9, 4'd15, 4'd13, 4'd6,
		  4'd1, 4'd12, 4'd0, 4'd2, 4'd11, 4'd7, 4'd5, 4'd3},
		'{4'd11, 4'd8, 4'd12, 4'd0, 4'd5, 4'd2, 4'd15, 4'd13,
		  4'd10, 4'd14, 4'd3, 4'd6, 4'd7, 4'd1, 4'd9, 4'd4},
		'{4'd7, 4'd9, 4'd3, 4'd1, 4'd13, 4'd12, 4'd11, 4'd14,
		  4'd2, 4'd6, 4'd5, 4'd10, 4'd4, 4'd0, 4'd15, 4'd8},
		'{4'd9, 4'd0, 4'd5, 4'd7, 4'd2, 4'd4, 4'd10, 4'd15,
		  4'd14, 4'd1, 4'd11, 4'd12, 4'd6, 4'd8, 4'd3, 4'd13},
		'{4'd2, 4'd12, 4'd6, 4'd10, 4'd0, 4'd11, 4'd8, 4'd3,
		  4'd4, 4'd13, 4'd7, 4'd5, 4'd15, 4'd14, 4'd1, 4'd9},
		'{4'd12, 4'd5, 4'd1, 4'd15, 4'd14, 4'd13, 4'd4, 4'd10,
		  4'd0, 4'd7, 4'd6, 4'd3, 4'd9, 4'd2, 4'd8, 4'd11},
		'{4'd13, 4'd11, 4'd7, 4'd14, 4'd12, 4'd1, 4'd3, 4'd9,
		  4'd5, 4'd0, 4'd15, 4'd4, 4'd8, 4'd6, 4'd2, 4'd10},
		'{4'd6, 4'd15, 4'd14, 4'd9, 4'd11, 4'd3, 4'd0, 4'd8,
		  4'd12, 4'd2, 4'd13, 4'd7, 4'd1, 4'd4, 4'd10, 4'd5},
		'{4'd10, 4'd2, 4'd8, 4'd4, 4'd7, 4'd6, 4'd1, 4'd5,
		  4'd15, 4'd11, 4'd9, 4'd14, 4'd3, 4'd12, 4'd13, 4'd0}
	};

endpackage

>>> src/b2b_if.sv
// ----------------------------------------------------------------------------
// b2b channel interfaces
// Request, digest and configuration channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface b2b_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  action;
	logic [63:0] data_word;
	modport source (output valid, action, data_word, input ready);
	modport sink (input valid, action, data_word, output ready);
endinterface

interface b2b_rsp_if;
	logic        valid;
	logic        ready;
	logic [63:0] digest_word;
	logic [2:0]  digest_index;
	logic        last_word;
	modport source (output valid, digest_word, digest_index, last_word, input ready);
	modport sink (input valid, digest_word, digest_index, last_word, output ready);
endinterface

interface b2b_cfg_if;
	logic       valid;
	logic       ready;
	logic [1:0] index;
	logic [3:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

>>> src/b2b_mix.sv
// ----------------------------------------------------------------------------
// b2b_mix: one quarter of the BLAKE2b G function
// Steps 0 and 2 add into a and rotate d; steps 1 and 3 add into c and
// rotate b. The sequencer applies it four times per G.
// ----------------------------------------------------------------------------
module b2b_mix (
	input  logic [1:0]  step,
	input  logic [63:0] a,
	input  logic [63:0] b,
	input  logic [63:0] c,
	input  logic [63:0] d,
	input  logic [63:0] m,
	output logic [63:0] a_o,
	output logic [63:0] b_o,
	output logic [63:0] c_o,
	output logic [63:0] d_o
);
	logic [63:0] sum_a, x_d, sum_c, x_b;

	always_comb begin
		sum_a = a + b + m;
		x_d   = d ^ sum_a;
		sum_c = c + d;
		x_b   = b ^ sum_c;
		a_o = a;
		b_o = b;
		c_o = c;
		d_o = d;
		case (step)
			2'd0: begin
				a_o = sum_a;
				d_o = {x_d[31:0], x_d[63:32]};
			end
			2'd1: begin
				c_o = sum_c;
				b_o = {x_b[23:0], x_b[63:24]};
			end
			2'd2: begin
				a_o = sum_a;
				d_o = {x_d[15:0], x_d[63:16]};
			end
			default: begin
				c_o = sum_c;
				b_o = {x_b[62:0], x_b[63]};
			end
		endcase
	end
endmodule

>>> src/blake2b_word_hash_engine.sv
// ----------------------------------------------------------------------------
// blake2b_word_hash_engine: BLAKE2b over 64-bit message words
// Keyed or unkeyed BLAKE2b with a configurable digest length.
// ----------------------------------------------------------------------------
// Begin, key and buffered data requests are taken in the idle state. A data request
// arriving on a full block and every finish request run one compression on
// a single shared quarter-G unit: a setup state, 12 rounds of 8 G functions
// built from quarter-G steps and a feed-forward state, during which the
// request channel is not ready. A finish then presents one digest word per
// cycle while the digest channel is ready. Over a block of 16 words the
// throughput is set by the quarter-G unit.
module blake2b_word_hash_engine (
	input  logic clk,
	input  logic arst_n,
	b2b_req_if.sink   req,
	b2b_rsp_if.source rsp,
	b2b_cfg_if.sink   cfg
);
	b2b_pkg::st_t st_q, st_d;
	logic [1:0]  step_q;
	logic [2:0]  g_q;
	logic [3:0]  r_q, s_q;
	logic [2:0]  e_q;
	logic [63:0] v_q [16];
	logic [63:0] v_d [16];
	logic [63:0] t_v [16];
	logic [63:0] h_q [8];
	logic [63:0] mem [16];
	logic [15:0] vld_q;
	logic [4:0]  fill_q;
	logic [3:0]  ks_q, ld_q, lk_q, dw_q, kl_q;
	logic [63:0] cnt_lo_q, cnt_hi_q;
	logic        last_q, pend_q;
	logic [63:0] pw_q, rd_q;
	logic        rmask_q;
	logic [3:0]  raddr;
	logic [2:0]  g_n;
	logic [3:0]  s_n;
	logic [3:0]  ld_b, lk_b;
	logic        acc, do_begin, key_ok, data_ok, blk_full;
	logic [4:0]  fin_fill;
	logic [1:0]  rot [4];
	logic [63:0] a_o, b_o, c_o, d_o, m_w;
	logic [64:0] lo_sum;
	logic [7:0]  add_n;
	logic        cnt_en;

	assign acc      = req.valid && req.ready;
	assign key_ok   = ks_q < lk_q;
	assign data_ok  = !key_ok;
	assign blk_full = fill_q[4];
	assign fin_fill = key_ok ? 5'd16 : fill_q;
	assign m_w      = rmask_q ? rd_q : 64'd0;

	// Clamped register values taken at each begin.
	assign ld_b = (dw_q == 4'd0) ? 4'd1 : ((dw_q > 4'd8) ? 4'd8 : dw_q);
	assign lk_b = (kl_q > 4'd8) ? 4'd8 : kl_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dw_q <= 4'd8;
			kl_q <= 4'd0;
		end else if (cfg.valid) begin
			if (cfg.index == b2b_pkg::CFG_DIGEST_WORDS) dw_q <= cfg.data;
			else if (cfg.index == b2b_pkg::CFG_KEY_WORDS) kl_q <= cfg.data;
		end
	end

	// Schedule position of the G function after the current one.
	assign g_n = g_q + 3'd1;
	assign s_n = (g_q == 3'd7) ? ((s_q == b2b_pkg::LAST_SIGMA) ? 4'd0 : s_q + 4'd1) : s_q;

	// The setup cycle fetches the first word of round zero, since the
	// schedule counters still hold the end of the previous compression.
	always_comb begin
		if (st_q == b2b_pkg::ST_MIX && step_q == 2'd1)
			raddr = b2b_pkg::SIGMA[s_q][{g_q, 1'b1}];
		else if (st_q == b2b_pkg::ST_INIT)
			raddr = b2b_pkg::SIGMA[0][0];
		else
			raddr = b2b_pkg::SIGMA[s_n][{g_n, 1'b0}];
	end

	b2b_mix u_mix (
		.step(step_q), .a(v_q[0]), .b(v_q[4]), .c(v_q[8]), .d(v_q[12]), .m(m_w),
		.a_o(a_o), .b_o(b_o), .c_o(c_o), .d_o(d_o)
	);

	// G always works on column zero; rows are rotated after each G so the
	// next column or diagonal lands there.
	always_comb begin
		for (int i = 0; i < 16; i++) t_v[i] = v_q[i];
		t_v[0]  = a_o;
		t_v[4]  = b_o;
		t_v[8]  = c_o;
		t_v[12] = d_o;
		for (int r = 0; r < 4; r++) rot[r] = (step_q == 2'd3) ? 2'd1 : 2'd0;
		if (step_q == 2'd3 && g_q == 3'd3) begin
			rot[1] = 2'd2;
			rot[2] = 2'd3;
			rot[3] = 2'd0;
		end else if (step_q == 2'd3 && g_q == 3'd7) begin
			rot[1] = 2'd0;
			rot[2] = 2'd3;
			rot[3] = 2'd2;
		end
		for (int r = 0; r < 4; r++)
			for (int i = 0; i < 4; i++)
				v_d[r * 4 + i] = t_v[r * 4 + 32'(2'(i[1:0] + rot[r]))];
	end

	always_comb begin
		st_d      = st_q;
		req.ready = 1'b0;
		rsp.valid = 1'b0;
		do_begin  = 1'b0;
		case (st_q)
			b2b_pkg::ST_IDLE: begin
				req.ready = 1'b1;
				if (acc) begin
					if (req.action == b2b_pkg::ACT_BEGIN) do_begin = 1'b1;
					else if (req.action == b2b_pkg::ACT_FINISH) st_d = b2b_pkg::ST_INIT;
					else if (req.action == b2b_pkg::ACT_DATA && data_ok && blk_full)
						st_d = b2b_pkg::ST_INIT;
				end
			end
			b2b_pkg::ST_INIT: st_d = b2b_pkg::ST_MIX;
			b2b_pkg::ST_MIX: begin
				if (step_q == 2'd3 && g_q == 3'd7 && r_q == b2b_pkg::LAST_ROUND)
					st_d = b2b_pkg::ST_FINAL;
			end
			b2b_pkg::ST_FINAL: st_d = last_q ? b2b_pkg::ST_EMIT : b2b_pkg::ST_IDLE;
			b2b_pkg::ST_EMIT: begin
				rsp.valid = 1'b1;
				if (rsp.ready && e_q == 3'(ld_q - 4'd1)) begin
					do_begin = 1'b1;
					st_d = b2b_pkg::ST_IDLE;
				end
			end
			default: st_d = b2b_pkg::ST_IDLE;
		endcase
	end

	assign rsp.digest_word  = h_q[e_q];
	assign rsp.digest_index = e_q;
	assign rsp.last_word    = e_q == 3'(ld_q - 4'd1);

	always_comb begin
		cnt_en = 1'b0;
		add_n  = b2b_pkg::BLOCK_BYTES;
		if (st_q == b2b_pkg::ST_IDLE && acc) begin
			if (req.action == b2b_pkg::ACT_FINISH) begin
				cnt_en = 1'b1;
				add_n  = {fin_fill, 3'd0};
			end else if (req.action == b2b_pkg::ACT_DATA && data_ok && blk_full) begin
				cnt_en = 1'b1;
			end
		end
	end
	assign lo_sum = {1'b0, cnt_lo_q} + {57'd0, add_n};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= b2b_pkg::ST_IDLE;
			step_q <= 2'd0;
			g_q    <= 3'd0;
			r_q    <= 4'd0;
			s_q    <= 4'd0;
			e_q    <= 3'd0;
		end else begin
			st_q <= st_d;
			if (st_q == b2b_pkg::ST_INIT) begin
				step_q <= 2'd0;
				g_q    <= 3'd0;
				r_q    <= 4'd0;
				s_q    <= 4'd0;
			end else if (st_q == b2b_pkg::ST_MIX) begin
				step_q <= step_q + 2'd1;
				if (step_q == 2'd3) begin
					g_q <= g_n;
					s_q <= s_n;
					if (g_q == 3'd7) r_q <= r_q + 4'd1;
				end
			end
			if (st_q == b2b_pkg::ST_EMIT && rsp.ready)
				e_q <= (st_d == b2b_pkg::ST_IDLE) ? 3'd0 : e_q + 3'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++) h_q[i] <= b2b_pkg::IV[i];
			vld_q    <= 16'd0;
			fill_q   <= 5'd0;
			ks_q     <= 4'd0;
			ld_q     <= 4'd8;
			lk_q     <= 4'd0;
			cnt_lo_q <= 64'd0;
			cnt_hi_q <= 64'd0;
			last_q   <= 1'b0;
			pend_q   <= 1'b0;
		end else if (do_begin) begin
			for (int i = 1; i < 8; i++) h_q[i] <= b2b_pkg::IV[i];
			h_q[0]   <= b2b_pkg::IV[0] ^ b2b_pkg::PARAM_BASE ^ {49'd0, lk_b, 11'd0}
				^ {57'd0, ld_b, 3'd0};
			vld_q    <= 16'd0;
			fill_q   <= 5'd0;
			ks_q     <= 4'd0;
			ld_q     <= ld_b;
			lk_q     <= lk_b;
			cnt_lo_q <= 64'd0;
			cnt_hi_q <= 64'd0;
		end else begin
			if (cnt_en) begin
				cnt_lo_q <= lo_sum[63:0];
				if (lo_sum[64]) cnt_hi_q <= cnt_hi_q + 64'd1;
			end
			if (st_q == b2b_pkg::ST_IDLE && acc) begin
				case (req.action)
					b2b_pkg::ACT_KEY: begin
						if (key_ok) begin
							vld_q[ks_q] <= 1'b1;
							ks_q <= ks_q + 4'd1;
							if (ks_q + 4'd1 == lk_q) fill_q <= 5'd16;
						end
					end
					b2b_pkg::ACT_DATA: begin
						if (data_ok) begin
							if (blk_full) begin
								pend_q <= 1'b1;
								last_q <= 1'b0;
							end else begin
								vld_q[fill_q[3:0]] <= 1'b1;
								fill_q <= fill_q + 5'd1;
							end
						end
					end
					b2b_pkg::ACT_FINISH: begin
						fill_q <= fin_fill;
						last_q <= 1'b1;
					end
					default: ;
				endcase
			end
			if (st_q == b2b_pkg::ST_FINAL) begin
				for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] ^ v_q[i] ^ v_q[i + 8];
				if (pend_q) begin
					vld_q[0] <= 1'b1;
					fill_q   <= 5'd1;
					pend_q   <= 1'b0;
				end
			end
		end
	end

	// Message block storage with one registered read port.
	always_ff @(posedge clk) begin
		if (st_q == b2b_pkg::ST_IDLE && acc && req.action == b2b_pkg::ACT_KEY && key_ok)
			mem[ks_q] <= req.data_word;
		else if (st_q == b2b_pkg::ST_IDLE && acc && req.action == b2b_pkg::ACT_DATA
				&& data_ok && !blk_full)
			mem[fill_q[3:0]] <= req.data_word;
		else if (st_q == b2b_pkg::ST_FINAL && pend_q)
			mem[0] <= pw_q;
		if (st_q == b2b_pkg::ST_IDLE && acc) pw_q <= req.data_word;
		rd_q    <= mem[raddr];
		rmask_q <= vld_q[raddr] && ({1'b0, raddr} < fill_q);
	end

	always_ff @(posedge clk) begin
		if (st_q == b2b_pkg::ST_INIT) begin
			for (int i = 0; i < 8; i++) begin
				v_q[i]     <= h_q[i];
				v_q[i + 8] <= b2b_pkg::IV[i];
			end
			v_q[12] <= b2b_pkg::IV[4] ^ cnt_lo_q;
			v_q[13] <= b2b_pkg::IV[5] ^ cnt_hi_q;
			v_q[14] <= b2b_pkg::IV[6] ^ {64{last_q}};
		end else if (st_q == b2b_pkg::ST_MIX) begin
			for (int i = 0; i < 16; i++) v_q[i] <= v_d[i];
		end
	end

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= 5'd16)
		else $error("block fill beyond sixteen words");

	a_key_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ks_q <= lk_q && lk_q <= 4'd8)
		else $error("key word count beyond latched key length");

	a_finish_busy: assert property (@(posedge clk) disable iff (!arst_n)
		acc && req.action == b2b_pkg::ACT_FINISH |=> !req.ready && !rsp.valid)
		else $error("finish request did not start a compression");

	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.ready && rsp.last_word |=> st_q == b2b_pkg::ST_IDLE && fill_q == 5'd0)
		else $error("engine not restarted after last digest word");

	a_digest_len: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> ld_q >= 4'd1 && ld_q <= 4'd8 && !pend_q)
		else $error("digest presented with bad length or pending word");
endmodule
